[design/sspq_pkg.sv]
// Shared types and constants for the stable sorted priority queue.
package sspq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 5;
	localparam int PAY_W    = 32;
	localparam int PRIO_W   = 16;
	localparam int CMD_W    = 2;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 40;

	localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SERVE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELABEL = 2'd2;

	// one stored entry of the sorted row
	typedef struct packed {
		logic                     valid;
		logic signed [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]         payload;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic                     insert;
		logic                     serve;
		logic                     relabel;
		logic signed [PRIO_W-1:0] prio;
		logic signed [PRIO_W-1:0] new_prio;
		logic [PAY_W-1:0]         payload;
	} cell_ctrl_t;

endpackage

[design/stable_sorted_priority_queue.sv]
// Top level of the stable sorted priority queue: a row of sorting cells and a result register.
//
// Usage:
//   Commands arrive as beats on the s_ channel; each accepted beat yields exactly
//   one result beat on the m_ channel. Commands: insert (payload, prio), serve
//   head, relabel (every held entry at prio becomes new_prio, order untouched).
//   Entries are held in descending priority; equal priorities leave in arrival
//   order. An insert into a full queue is dropped and flagged.
//   Latency: the result beat is valid the cycle after the command is accepted.
//   Throughput: one command per cycle while s_tready is high; all CAPACITY
//   cells compare and shift in parallel, the only serial path being the
//   insertion-point chain through the cells.
//   Stall: while the result register is full and m_tready is low, s_tready is
//   low; the result register frees itself as soon as its beat is taken.
//   Reset: arst_n clears the queue to empty and drops any pending result.
//   No clearing pass is needed; commands are taken from the first cycle.
module stable_sorted_priority_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// cmd[1:0], payload[33:2], prio[49:34], new_prio[65:50], zero fill to 72
	input  logic [sspq_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// out_payload[31:0], out_valid[32], dropped[33], occupancy[38:34], zero fill
	output logic [sspq_pkg::OUT_W-1:0]   m_tdata
);
	import sspq_pkg::*;

	logic [CMD_W-1:0]         cmd;
	logic [PAY_W-1:0]         in_payload;
	logic signed [PRIO_W-1:0] in_prio;
	logic signed [PRIO_W-1:0] in_new_prio;
	logic                     accept;
	logic                     full;
	logic                     empty;
	cell_ctrl_t               ctrl;
	entry_t                   ent [CAPACITY];
	logic [CAPACITY:0]        done;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic                     m_tvalid_q;
	logic [OUT_W-1:0]         m_tdata_q;
	logic [PAY_W-1:0]         res_payload;
	logic                     res_valid;
	logic                     res_dropped;

	// unpack the command beat
	assign cmd         = s_tdata[1:0];
	assign in_payload  = s_tdata[33:2];
	assign in_prio     = s_tdata[49:34];
	assign in_new_prio = s_tdata[65:50];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	// broadcast the decoded command to the row
	always_comb begin
		ctrl.insert   = accept && (cmd == CMD_INSERT) && !full;
		ctrl.serve    = accept && (cmd == CMD_SERVE) && !empty;
		ctrl.relabel  = accept && (cmd == CMD_RELABEL);
		ctrl.prio     = in_prio;
		ctrl.new_prio = in_new_prio;
		ctrl.payload  = in_payload;
	end

	assign done[0] = 1'b0;

	// build the row of cells, head at index zero
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		if (i == 0) begin : g_head
			assign left_e = '0;
		end else begin : g_mid
			assign left_e = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = ent[i+1];
		end
		sspq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.left     (left_e),
			.right    (right_e),
			.done_in  (done[i]),
			.done_out (done[i+1]),
			.ent      (ent[i])
		);
	end

	// advance the fill count and form the result
	always_comb begin
		count_d     = count_q;
		res_payload = '0;
		res_valid   = 1'b0;
		res_dropped = 1'b0;
		if (ctrl.insert) begin
			count_d = count_q + CNT_W'(1);
		end
		if (ctrl.serve) begin
			count_d     = count_q - CNT_W'(1);
			res_payload = ent[0].payload;
			res_valid   = 1'b1;
		end
		if (accept && (cmd == CMD_INSERT) && full) begin
			res_dropped = 1'b1;
		end
	end

	// hold count and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {1'b0, OCC_W'(count_d), res_dropped, res_valid, res_payload};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[design/sspq_cell.sv]
// One compare-and-shift cell of the sorted row.
module sspq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sspq_pkg::cell_ctrl_t ctrl,
	input  sspq_pkg::entry_t    left,
	input  sspq_pkg::entry_t    right,
	input  logic                done_in,
	output logic                done_out,
	output sspq_pkg::entry_t    ent
);
	import sspq_pkg::*;

	logic                     valid_q;
	logic signed [PRIO_W-1:0] prio_q;
	logic [PAY_W-1:0]         payload_q;
	entry_t                   ent_q;
	entry_t                   ent_d;
	logic                     take;

	assign ent_q = {valid_q, prio_q, payload_q};

	// claim the new entry here if empty or holding a strictly lower priority
	assign take     = !ent_q.valid || (ent_q.prio < ctrl.prio);
	assign done_out = done_in || take;
	assign ent      = ent_q;

	// pick next contents: shift in from the left, place, pull from the right, relabel
	always_comb begin
		ent_d = ent_q;
		if (ctrl.insert) begin
			if (done_in) begin
				ent_d = left;
			end else if (take) begin
				ent_d.valid   = 1'b1;
				ent_d.prio    = ctrl.prio;
				ent_d.payload = ctrl.payload;
			end
		end else if (ctrl.serve) begin
			ent_d = right;
		end else if (ctrl.relabel) begin
			if (ent_q.valid && (ent_q.prio == ctrl.prio)) begin
				ent_d.prio = ctrl.new_prio;
			end
		end
	end

	// hold occupancy flag under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ent_d.valid;
		end
	end

	// data needs no reset
	always_ff @(posedge clk) begin
		prio_q    <= ent_d.prio;
		payload_q <= ent_d.payload;
	end

endmodule
